@@ rtl/lmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmsc_pkg
// Shared types, constants and the brightness functions of the LED matrix
// scan controller.
// ----------------------------------------------------------------------------
package lmsc_pkg;

  localparam int NUM_LINES = 16;
  localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int CNT_W     = $clog2(NUM_LINES + 1);
  localparam int WORD_W    = 32;
  localparam int MEM_W     = 2 * WORD_W;

  localparam logic [WORD_W-1:0] BLANK_WORD = {WORD_W{1'b1}};

  localparam logic [9:0] ILLUM_HIGH = 10'd900;
  localparam logic [9:0] ILLUM_LOW  = 10'd24;
  localparam logic [9:0] ON_MAX     = 10'd512;
  localparam logic [9:0] ON_MIN     = 10'd1;
  localparam logic [9:0] ON_OFFSET  = 10'd10;
  localparam logic [9:0] LINE_TIME  = 10'd492;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SHOW  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [LINE_W-1:0] rd_addr;
    logic              wr_en;
    logic [LINE_W-1:0] wr_addr;
    logic [MEM_W-1:0]  wr_data;
    logic              clr;
  } store_req_t;

  function automatic logic [9:0] on_time_of(input logic [9:0] illum);
    logic [9:0] t;
    if (illum > ILLUM_HIGH) begin
      t = ON_MAX;
    end else if (illum < ILLUM_LOW) begin
      t = ON_MIN;
    end else begin
      t = {1'b0, illum[9:1]} - ON_OFFSET;
    end
    return t;
  endfunction

  function automatic logic [8:0] off_time_of(input logic [9:0] on_t);
    logic [9:0] d;
    d = LINE_TIME - on_t;
    if (on_t >= LINE_TIME) begin
      return 9'd0;
    end
    return d[8:0];
  endfunction

endpackage

@@ rtl/led_matrix_scan_controller.sv @@
// ----------------------------------------------------------------------------
// led_matrix_scan_controller
// Two-color LED matrix frame store with line scan output.
//
// Input channel (in_valid/in_stall) carries one command word: set pixel,
// clear frame or show frame. Output channel (out_valid/out_stall) carries
// line words: line select, green and red words (active low), on and off time.
// Set pixel is a read-modify-write of one frame store entry: a read on accept,
// then a write, input stalled during the write cycle. Clear frame drops all
// per-line valid bits at once. Show frame reads one line per cycle from the
// frame store port while the output does not stall and issues NUM_LINES line
// words, the last flagged with last_line. Input is stalled until the last
// line word is loaded into the output register.
// A stalled output word holds; the one-entry read pipeline behind it holds
// too, so no line is lost or repeated.
// Reset blanks the frame (all ones) and empties the output register.
// ----------------------------------------------------------------------------
module led_matrix_scan_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic        pixel_on,
  input  logic [4:0]  col,
  input  logic [3:0]  row,
  input  logic        color,
  input  logic [9:0]  illum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  line_sel,
  output logic [31:0] green_word,
  output logic [31:0] red_word,
  output logic [9:0]  on_time,
  output logic [8:0]  off_time,
  output logic        last_line
);
  import lmsc_pkg::*;

  state_t            state, state_next;
  store_req_t        req;
  logic [MEM_W-1:0]  rd_data;

  logic              accept;
  logic              load;
  logic              dat_last;
  logic              issue_done;

  logic [LINE_W-1:0] set_addr;
  logic [4:0]        set_col;
  logic              set_lit;
  logic              set_plane;
  logic [9:0]        on_reg;
  logic [8:0]        off_reg;
  logic [CNT_W-1:0]  issue_cnt;
  logic              data_vld;
  logic [LINE_W-1:0] dat_line;

  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] new_word;

  lmsc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign load       = (state == ST_SHOW) && data_vld && (!out_valid || !out_stall);
  assign dat_last   = (dat_line == LINE_W'(NUM_LINES - 1));
  assign issue_done = (issue_cnt == CNT_W'(NUM_LINES));

  assign cur_word = set_plane ? rd_data[WORD_W-1:0] : rd_data[MEM_W-1:WORD_W];
  assign bit_mask = WORD_W'(1) << (~set_col);
  assign new_word = set_lit ? (cur_word & ~bit_mask) : (cur_word | bit_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(cmd))
            CMD_SET: begin
              if ({1'b0, row} < 5'(NUM_LINES)) begin
                req.rd_en   = 1'b1;
                req.rd_addr = row[LINE_W-1:0];
                state_next  = ST_SET_WR;
              end
            end
            CMD_CLEAR: begin
              req.clr = 1'b1;
            end
            CMD_SHOW: begin
              state_next = ST_SHOW;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SET_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = set_addr;
        req.wr_data = set_plane ? {rd_data[MEM_W-1:WORD_W], new_word}
                                : {new_word, rd_data[WORD_W-1:0]};
        state_next  = ST_IDLE;
      end
      ST_SHOW: begin
        if ((!data_vld || load) && !issue_done) begin
          req.rd_en   = 1'b1;
          req.rd_addr = issue_cnt[LINE_W-1:0];
        end
        if (load && dat_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      set_addr  <= row[LINE_W-1:0];
      set_col   <= col;
      set_lit   <= pixel_on;
      set_plane <= color;
      on_reg    <= on_time_of(illum);
      off_reg   <= off_time_of(on_time_of(illum));
    end
  end

  // show read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      data_vld  <= 1'b0;
    end else if (accept) begin
      issue_cnt <= '0;
      data_vld  <= 1'b0;
    end else if (state == ST_SHOW) begin
      if (req.rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      data_vld <= req.rd_en || (data_vld && !load);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SHOW) && req.rd_en) begin
      dat_line <= req.rd_addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_sel   <= 4'(dat_line);
      green_word <= rd_data[MEM_W-1:WORD_W];
      red_word   <= rd_data[WORD_W-1:0];
      on_time    <= on_reg;
      off_time   <= off_reg;
      last_line  <= dat_last;
    end
  end

  a_show_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |-> in_stall)
    else $error("input taken during show");

  a_last_line_ends_show: assert property (@(posedge clk) disable iff (rst)
    (load && dat_last) |=> (state == ST_IDLE))
    else $error("show did not end after last line");

  a_held_data_stable: assert property (@(posedge clk) disable iff (rst)
    (data_vld && (state == ST_SHOW) && !load) |=>
      (data_vld && $stable(dat_line) && $stable(rd_data)))
    else $error("pending line data lost");

  a_no_write_with_clear: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && (req.clr || req.rd_en)))
    else $error("store write overlaps clear or read");

  a_set_write_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SET_WR) |=> (state == ST_IDLE))
    else $error("set write not single cycle");

endmodule

@@ rtl/lmsc_store.sv @@
// ----------------------------------------------------------------------------
// lmsc_store
// Frame store: one 64-bit entry per line, green word high, red word low.
// Per-line valid bits stand in for the blank reset value; clear drops them all.
// ----------------------------------------------------------------------------
module lmsc_store (
  input  logic                         clk,
  input  logic                         rst,
  input  lmsc_pkg::store_req_t         req,
  output logic [lmsc_pkg::MEM_W-1:0]   rd_data
);
  import lmsc_pkg::*;

  logic [MEM_W-1:0]     mem [NUM_LINES];
  logic [NUM_LINES-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= vld[req.rd_addr] ? mem[req.rd_addr] : {BLANK_WORD, BLANK_WORD};
    end
  end

endmodule
